// File: hdl/lkv_pkg.sv
`default_nettype none
package lkv_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned CAP_W       = 5;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned VAL_W       = 32;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } rsp_t;

endpackage
`default_nettype wire

// File: hdl/lkv_store.sv
`default_nettype none
module lkv_store #(
  parameter int unsigned ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     fire,
  input  wire lkv_pkg::req_t            req,
  input  wire logic [lkv_pkg::CAP_W-1:0] cap,
  output lkv_pkg::rsp_t                 rsp
);

  localparam int unsigned RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned COUNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W   = (COUNT_W > lkv_pkg::CAP_W) ? COUNT_W : lkv_pkg::CAP_W;

  logic [ENTRIES-1:0]               valid_r, valid_nxt;
  logic [lkv_pkg::KEY_W-1:0]        key_r   [ENTRIES];
  logic [lkv_pkg::VAL_W-1:0]        val_r   [ENTRIES];
  logic [RANK_W-1:0]                rank_r  [ENTRIES];
  logic [RANK_W-1:0]                rank_nxt[ENTRIES];
  logic [COUNT_W-1:0]               count_r, count_nxt;

  logic                             is_put;
  logic [ENTRIES-1:0]               match;
  logic [ENTRIES-1:0]               victim;
  logic [ENTRIES-1:0]               victim_sel;
  logic [ENTRIES-1:0]               free_vec;
  logic [ENTRIES-1:0]               free_oh;
  logic [RANK_W-1:0]                hit_rank;
  logic [RANK_W-1:0]                lru_rank;
  logic [lkv_pkg::VAL_W-1:0]        hit_val;
  logic [lkv_pkg::KEY_W-1:0]        vic_key;
  logic                             hit;
  logic                             evict;
  logic                             insert;
  logic [CMP_W-1:0]                 cap_ext;
  logic [CMP_W-1:0]                 cap_eff;
  logic [CMP_W-1:0]                 count_ext;

  assign is_put   = (req.req_type == lkv_pkg::REQ_PUT);
  assign lru_rank = RANK_W'(count_r - COUNT_W'(1));

  // Parallel compare of every slot against the key, and a search for the slot
  // that holds the oldest rank.
  always_comb begin
    match    = '0;
    victim   = '0;
    hit_rank = '0;
    hit_val  = '0;
    vic_key  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_r[i] && (key_r[i] == req.key);
      victim[i] = valid_r[i] && (rank_r[i] == lru_rank);
      if (match[i]) begin
        hit_rank = hit_rank | rank_r[i];
        hit_val  = hit_val | val_r[i];
      end
      if (victim[i]) begin
        vic_key = vic_key | key_r[i];
      end
    end
  end

  // A capacity of zero acts as one, and one above the store size as the size.
  always_comb begin
    cap_ext   = CMP_W'(cap);
    count_ext = CMP_W'(count_r);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign hit        = |match;
  assign evict      = is_put && !hit && (count_ext >= cap_eff) && (count_r != '0) && (|victim);
  assign victim_sel = evict ? victim : '0;
  assign free_vec   = ~(valid_r & ~victim_sel);
  assign free_oh    = free_vec & (~free_vec + ENTRIES'(1));
  assign insert     = is_put && !hit && (|free_vec);

  always_comb begin
    valid_nxt = (valid_r & ~victim_sel) | (insert ? free_oh : '0);
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (hit) begin
        if (match[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
          rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
      end else if (insert) begin
        if (free_oh[i] || victim_sel[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i]) begin
          rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
      end
    end
    count_nxt = count_r - COUNT_W'(evict) + COUNT_W'(insert);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (fire) begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (insert && free_oh[i]) begin
          key_r[i] <= req.key;
          val_r[i] <= req.value;
        end else if (is_put && match[i]) begin
          val_r[i] <= req.value;
        end
      end
    end
  end

  always_comb begin
    rsp.hit         = hit;
    rsp.evicted     = evict;
    rsp.evicted_key = evict ? vic_key : '0;
    if (is_put) begin
      rsp.read_value = '0;
    end else if (hit) begin
      rsp.read_value = hit_val;
    end else begin
      rsp.read_value = lkv_pkg::MISS_VALUE;
    end
  end

endmodule
`default_nettype wire

// File: hdl/lru_key_value_cache_top.sv
`default_nettype none
// Fully associative key-value cache with least-recently-used replacement.
// Each input item is a get or a put of a 32-bit key; each yields exactly one
// result item with the hit flag, the read value (-1 on a get miss, 0 on a
// put) and the key of any entry that a put evicted. The block takes one item
// per clock cycle while the output is not stalled. Each item is registered
// in the input register while a single pass of parallel key compare and rank
// update over the entry registers settles, and the result register takes
// the outcome when the output is free. That pass also fixes the clock rate.
// A stalled output backs up through the input register. The capacity
// register may be written only while no item is in flight.
module lru_key_value_cache_top #(
  parameter int unsigned ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // key [31:0], value [63:32]
  input  wire logic [0:0]  in_tuser,   // req_type [0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // hit [0], read_value [32:1], evicted [33],
                                       // evicted_key [65:34], zero [71:66]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data    // capacity_in_use
);

  logic                         in_valid_r;
  lkv_pkg::req_t                in_req_r;
  logic                         out_valid_r;
  lkv_pkg::rsp_t                out_rsp_r;
  lkv_pkg::rsp_t                rsp;
  logic [lkv_pkg::CAP_W-1:0]    cap_r;
  logic                         proc_fire;

  assign proc_fire = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc_fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkv_pkg::CAP_RESET;
    end else if (cfg_valid) begin
      cap_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (proc_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_req_r.req_type <= in_tuser[0];
      in_req_r.key      <= in_tdata[31:0];
      in_req_r.value    <= in_tdata[63:32];
    end
    if (proc_fire) begin
      out_rsp_r <= rsp;
    end
  end

  lkv_store #(
    .ENTRIES(ENTRIES)
  ) u_store (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (proc_fire),
    .req  (in_req_r),
    .cap  (cap_r),
    .rsp  (rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_rsp_r.evicted_key, out_rsp_r.evicted,
                       out_rsp_r.read_value, out_rsp_r.hit};

endmodule
`default_nettype wire

// File: tb/sv/lkv_result_checker.sv
`default_nettype none
// Watches the request, result and capacity channels of the cache, keeps its own
// copy of the entry store and compares every result item with the oldest
// expected one.
module lkv_result_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [63:0] in_tdata,   // key [31:0], value [63:32]
  input  wire logic [0:0]  in_tuser,   // req_type [0]
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [71:0] out_tdata,  // hit [0], read_value [32:1], evicted [33],
                                       // evicted_key [65:34], zero [71:66]
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [4:0]  cfg_data,   // capacity_in_use
  output int               mismatches,
  output int               pending,
  output int               results_seen,
  output int               hits_seen,
  output int               evictions_seen
);
  import lkv_pkg::*;

  localparam int SLOTS = ENTRIES_DEF;

  logic             slot_valid [SLOTS];
  logic [KEY_W-1:0] slot_key   [SLOTS];
  logic [VAL_W-1:0] slot_val   [SLOTS];
  logic [3:0]       slot_rank  [SLOTS];
  logic [CAP_W-1:0] live_count;
  logic [CAP_W-1:0] capacity;
  rsp_t             expected_rsp_q [$];

  // Every valid entry more recent than slot s ages by one; s becomes rank 0.
  function automatic void make_most_recent(input int s);
    logic [3:0] r;
    r = slot_rank[s];
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_valid[i] && i != s && slot_rank[i] < r) begin
        slot_rank[i] = slot_rank[i] + 4'd1;
      end
    end
    slot_rank[s] = 4'd0;
  endfunction

  function automatic int unsigned allowed_entries();
    int unsigned c;
    c = capacity;
    if (c == 0) begin
      c = 1;
    end
    if (c > SLOTS) begin
      c = SLOTS;
    end
    return c;
  endfunction

  function automatic rsp_t predict_access(input logic req, input logic [KEY_W-1:0] k,
                                          input logic [VAL_W-1:0] v);
    rsp_t r;
    int   s;
    int   free_slot;
    r = '0;
    s = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (s < 0 && slot_valid[i] && slot_key[i] == k) begin
        s = i;
      end
    end
    r.hit = (s >= 0);
    if (req == REQ_GET) begin
      if (s >= 0) begin
        r.read_value = slot_val[s];
        make_most_recent(s);
      end else begin
        r.read_value = MISS_VALUE;
      end
    end else if (s >= 0) begin
      slot_val[s] = v;
      make_most_recent(s);
    end else begin
      // A new key evicts at most one entry, even when the capacity was lowered
      // below the current count.
      if (live_count >= allowed_entries() && live_count > 0) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!r.evicted && slot_valid[i] && slot_rank[i] == live_count - 5'd1) begin
            r.evicted     = 1'b1;
            r.evicted_key = slot_key[i];
            slot_valid[i] = 1'b0;
            slot_rank[i]  = 4'd0;
            live_count    = live_count - 5'd1;
          end
        end
      end
      free_slot = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (free_slot < 0 && !slot_valid[i]) begin
          free_slot = i;
        end
      end
      if (free_slot >= 0) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i]) begin
            slot_rank[i] = slot_rank[i] + 4'd1;
          end
        end
        slot_valid[free_slot] = 1'b1;
        slot_key[free_slot]   = k;
        slot_val[free_slot]   = v;
        slot_rank[free_slot]  = 4'd0;
        live_count            = live_count + 5'd1;
      end
    end
    return r;
  endfunction

  function automatic bit field_differs(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t got;
    rsp_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_valid[i] = 1'b0;
        slot_key[i]   = '0;
        slot_val[i]   = '0;
        slot_rank[i]  = 4'd0;
      end
      live_count = '0;
      capacity   = CAP_RESET;
      expected_rsp_q.delete();
      pending = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.hit         = out_tdata[0];
        got.read_value  = out_tdata[32:1];
        got.evicted     = out_tdata[33];
        got.evicted_key = out_tdata[65:34];
        results_seen++;
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected result item, expected none actual %h", $time, got);
          mismatches++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (field_differs("hit", want.hit, got.hit)) mismatches++;
          if (field_differs("read_value", want.read_value, got.read_value)) mismatches++;
          if (field_differs("evicted", want.evicted, got.evicted)) mismatches++;
          if (field_differs("evicted_key", want.evicted_key, got.evicted_key)) mismatches++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        capacity = cfg_data;
      end
      if (in_tvalid && in_tready) begin
        want = predict_access(in_tuser[0], in_tdata[31:0], in_tdata[63:32]);
        expected_rsp_q.push_back(want);
        hits_seen      += want.hit;
        evictions_seen += want.evicted;
      end
      pending = expected_rsp_q.size();
    end
  end

endmodule
`default_nettype wire

// File: tb/sv/tb_lru_key_value_cache_top.sv
`default_nettype none
module tb_lru_key_value_cache_top;
  import lkv_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 110;
  localparam int POOL_SIZE      = 32;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [63:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [4:0]  cfg_data   = '0;
  wire logic        in_tready;
  wire logic        out_tvalid;
  wire logic [71:0] out_tdata;
  wire logic        cfg_ready;

  int mismatches;
  int pending;
  int results_seen;
  int hits_seen;
  int evictions_seen;
  int cycles;
  int reqs_sent;
  int settings_used = 1;
  bit send_burst;
  bit hold_req;
  bit hold_taken;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  lru_key_value_cache_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  lkv_result_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .pending        (pending),
    .results_seen   (results_seen),
    .hits_seen      (hits_seen),
    .evictions_seen (evictions_seen)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, pending);
      $display("FAIL");
      $finish;
    end
  end

  function automatic int next_gap();
    if ($urandom_range(0, 63) == 0) begin
      send_burst = !send_burst;
    end
    return send_burst ? 0 : $urandom_range(0, 10);
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_req(input logic req, input logic [KEY_W-1:0] k,
                          input logic [VAL_W-1:0] v, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {v, k};
    in_tuser  <= req;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    reqs_sent++;
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_pool_req(input int pool_span, input int gap);
    logic [KEY_W-1:0] k;
    if ($urandom_range(0, 15) == 0) begin
      k = $urandom;
    end else begin
      k = key_pool[$urandom_range(0, pool_span - 1)];
    end
    send_req(logic'($urandom_range(0, 1)), k, $urandom, gap);
  endtask

  function automatic logic [CAP_W-1:0] phase_capacity(input int ph);
    case (ph)
      0: return 5'd16;
      1: return 5'd1;
      2: return 5'd2;
      3: return 5'd0;
      4: return 5'd31;
      5: return 5'd3;   // drops well below the count left by the previous phase
      6: return 5'd17;
      7: return 5'd8;
      8: return 5'd15;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  initial begin : result_sink
    int  wait_cycles;
    bit  sink_burst;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) begin
        sink_burst = !sink_burst;
      end
      wait_cycles = sink_burst ? 0 : $urandom_range(0, 10);
      if (hold_req && !hold_taken) begin
        hold_taken  = 1'b1;
        wait_cycles = HOLD_CYCLES;
      end
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [CAP_W-1:0] cap;
    int               pool_span;
    for (int j = 0; j < POOL_SIZE; j++) begin
      key_pool[j] = $urandom;
    end
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Key and value extremes, hits, misses and an update at the reset capacity.
    send_req(REQ_GET, 32'h0000_0000, 32'hDEAD_BEEF, next_gap());
    send_req(REQ_PUT, 32'h0000_0000, 32'h7FFF_FFFF, next_gap());
    send_req(REQ_PUT, 32'hFFFF_FFFF, 32'h8000_0000, next_gap());
    send_req(REQ_PUT, 32'h8000_0000, 32'hFFFF_FFFF, next_gap());
    send_req(REQ_PUT, 32'h7FFF_FFFF, 32'h0000_0000, next_gap());
    send_req(REQ_GET, 32'h0000_0000, 32'h0000_0000, next_gap());
    send_req(REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, next_gap());
    send_req(REQ_PUT, 32'h0000_0000, 32'h1234_5678, next_gap());
    send_req(REQ_GET, 32'h0000_0000, 32'h0000_0000, next_gap());
    send_req(REQ_GET, 32'h0000_0001, 32'h0000_0000, next_gap());
    // Capacity below the count: each new key evicts exactly one entry.
    write_capacity(5'd1);
    send_req(REQ_PUT, 32'h0000_0005, 32'hA5A5_A5A5, next_gap());
    send_req(REQ_GET, 32'h8000_0000, 32'h0000_0000, next_gap());
    send_req(REQ_PUT, 32'h0000_0006, 32'h5A5A_5A5A, next_gap());
    // A zero capacity behaves as one.
    write_capacity(5'd0);
    send_req(REQ_PUT, 32'h0000_0007, 32'h0000_0001, next_gap());
    send_req(REQ_GET, 32'h0000_0007, 32'h0000_0000, next_gap());
    // Above the store size the full store is used.
    write_capacity(5'd31);
    send_req(REQ_PUT, 32'h0000_0008, 32'h0000_0002, next_gap());
    send_req(REQ_PUT, 32'h0000_0009, 32'h0000_0003, next_gap());
    send_req(REQ_GET, 32'h0000_0008, 32'h0000_0000, next_gap());

    for (int ph = 0; ph < PHASES; ph++) begin
      cap = phase_capacity(ph);
      write_capacity(cap);
      // Keep about half of the keys so that earlier entries still hit.
      for (int j = 0; j < POOL_SIZE; j++) begin
        if ($urandom_range(0, 1) == 0) begin
          key_pool[j] = $urandom;
        end
      end
      pool_span = (cap == 0) ? 5 : (cap > 16) ? 20 : cap + 4;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 5 && n == 20) begin
          // The sink stalls for a long stretch while items keep coming back to back.
          hold_req = 1'b1;
          for (int h = 0; h < 40; h++) begin
            send_pool_req(pool_span, 0);
          end
        end
        send_pool_req(pool_span, next_gap());
      end
    end

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Sent %0d requests across %0d capacity settings, checked %0d results.",
             reqs_sent, settings_used, results_seen);
    $display("Predicted %0d hits and %0d evictions; %0d mismatches.",
             hits_seen, evictions_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
